/* hdl/kc_pkg.sv */
// kc_pkg: shared types and constants of the keystroke calculator
// key codes, operation and status codes, result field widths
// no dependencies
package kc_pkg;

  localparam int KEY_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int WHOLE_W    = 64;
  localparam int FRAC_OUT_W = 16;
  localparam int OP_W       = 3;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [WHOLE_W-1:0]    whole_t;
  typedef logic [FRAC_OUT_W-1:0] frac_t;
  typedef logic [OP_W-1:0]       op_t;

  // ascii key codes
  localparam key_t KEY_ZERO  = 8'd48;
  localparam key_t KEY_NINE  = 8'd57;
  localparam key_t KEY_ADD   = 8'd43;
  localparam key_t KEY_SUB   = 8'd45;
  localparam key_t KEY_MUL   = 8'd42;
  localparam key_t KEY_DIV   = 8'd47;
  localparam key_t KEY_POW   = 8'd94;
  localparam key_t KEY_ENTER = 8'd13;

  // pending operation codes
  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;
  localparam op_t OP_POW  = 3'd5;

  // result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_MISSING   = 3'd1;
  localparam status_t ST_DIV_ZERO  = 3'd2;
  localparam status_t ST_ZERO_ZERO = 3'd3;
  localparam status_t ST_OVERFLOW  = 3'd4;

  localparam whole_t WHOLE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

/* hdl/kc_key_if.sv */
// kc_key_if: valid/ready channel carrying one key code per transaction
// depends on kc_pkg
interface kc_key_if;
  import kc_pkg::*;

  logic valid;
  logic ready;
  key_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

/* hdl/kc_res_if.sv */
// kc_res_if: valid/ready channel carrying one calculator result per transaction
// depends on kc_pkg
interface kc_res_if;
  import kc_pkg::*;

  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic signed [WHOLE_W-1:0]  result_whole;
  frac_t                      result_fraction;

  modport source (output valid, output status, output result_whole,
                  output result_fraction, input ready);
  modport sink   (input valid, input status, input result_whole,
                  input result_fraction, output ready);
endinterface

/* hdl/keystroke_calculator_core.sv */
// keystroke_calculator_core: keypad integer calculator, one key per transaction
// one shared 65-bit adder/subtractor under a small sequencer does add, sub,
// shift-add multiply, restoring divide and square-and-multiply power
// depends on kc_pkg, kc_key_if, kc_res_if
//
// on the enter key the sequencer runs add/sub, multiply or divide; a missing operand
// or zero divisor goes straight to the emit state; power, N = OPERAND_BITS, does one
// 64-step square per exponent bit and one N-step multiply by the base per set bit,
// squares skipped while the accumulator is one
// digit keys and operators with an entry are taken one per cycle; the key channel is
// not ready while an enter key or an operator with no entry is being worked on, nor
// while its result waits for the output register to drain
// synchronous active-high reset clears the entry, held operand, pending operation,
// the sequencer state and the output valid flag
module keystroke_calculator_core #(
  parameter int OPERAND_BITS  = 31,
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  kc_key_if.sink   key,
  kc_res_if.source result
);
  import kc_pkg::*;

  localparam int OB     = OPERAND_BITS;
  localparam int QW     = OPERAND_BITS + FRACTION_BITS;   // quotient bits incl. fraction
  localparam int PAD    = WHOLE_W - OPERAND_BITS;
  localparam int CNT_W  = $clog2(((QW > WHOLE_W) ? QW : WHOLE_W) + 1);
  localparam int EB_W   = $clog2(OPERAND_BITS);
  localparam int AU_W   = WHOLE_W + 1;
  localparam int DIG_W  = OPERAND_BITS + 5;
  localparam logic [OB-1:0] OPERAND_MAX = {OB{1'b1}};

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADDSUB = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PSQ    = 3'd4;  // power: square step
  localparam logic [2:0] S_PBIT   = 3'd5;  // power: multiply by base if bit set
  localparam logic [2:0] S_PNEXT  = 3'd6;  // power: next exponent bit
  localparam logic [2:0] S_EMIT   = 3'd7;  // staged result waits for the output slot

  // calculator state
  logic [OB-1:0] entry_value;
  logic          entry_present;
  logic [OB-1:0] held_value;
  logic          held_present;
  op_t           pend;

  // sequencer and working registers
  logic [2:0]       state;
  logic [2:0]       ret_state;
  logic             mul_pow;
  op_t              wop;
  logic [OB-1:0]    wa;       // held operand, base of power
  logic [OB-1:0]    wb;       // entry operand, divisor or exponent
  logic [CNT_W-1:0] cnt;
  logic [EB_W-1:0]  ebit;
  whole_t           acc;      // power accumulator
  whole_t           mx;       // multiplicand
  whole_t           my;       // multiplier, consumed msb first
  whole_t           prod;
  logic [OB-1:0]    rem;
  logic [QW-1:0]    quo;      // dividend bits out, quotient bits in

  // staged result and output register
  status_t st_status;
  whole_t  st_whole;
  frac_t   st_frac;
  logic    out_valid;
  status_t out_status;
  whole_t  out_whole;
  frac_t   out_frac;

  // shared arithmetic unit
  logic [AU_W-1:0] au_a;
  logic [AU_W-1:0] au_b;
  logic            au_sub;
  logic [AU_W-1:0] au_sum;
  logic            au_ovf;     // product above the largest signed 64-bit value
  logic            div_neg;    // trial subtraction borrowed
  logic [OB:0]     div_trial;

  // key decode
  logic          key_fire;
  logic          is_digit;
  logic          is_enter;
  op_t           key_op;
  logic [DIG_W-1:0] digit_sum;
  logic [OB-1:0] digit_next;
  logic          enter_missing;

  // ---------------------------------------------------------------------------
  // key decode and decimal entry
  // ---------------------------------------------------------------------------
  assign key_fire = key.valid & key.ready;

  always_comb begin
    is_digit = 1'b0;
    is_enter = 1'b0;
    key_op   = OP_NONE;
    unique case (key.key_code) inside
      [KEY_ZERO:KEY_NINE]: is_digit = 1'b1;
      KEY_ADD:             key_op   = OP_ADD;
      KEY_SUB:             key_op   = OP_SUB;
      KEY_MUL:             key_op   = OP_MUL;
      KEY_DIV:             key_op   = OP_DIV;
      KEY_POW:             key_op   = OP_POW;
      KEY_ENTER:           is_enter = 1'b1;
      default:             ;
    endcase
  end

  // entry * 10 + digit, saturated
  assign digit_sum = ({2'b00, entry_value, 3'b000} + {4'b0000, entry_value, 1'b0})
                   + DIG_W'(key.key_code - KEY_ZERO);
  assign digit_next = !entry_present ? OB'(key.key_code - KEY_ZERO)
                    : (digit_sum > DIG_W'(OPERAND_MAX)) ? OPERAND_MAX
                    : digit_sum[OB-1:0];

  assign enter_missing = !entry_present || !held_present || (pend == OP_NONE) ||
                         (pend > OP_POW);

  // ---------------------------------------------------------------------------
  // shared adder/subtractor, operands picked by the sequencer state
  // ---------------------------------------------------------------------------
  assign div_trial = {rem, quo[QW-1]};

  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    case (state)
      S_ADDSUB: begin
        au_a   = AU_W'(wa);
        au_b   = AU_W'(wb);
        au_sub = (wop == OP_SUB);
      end
      S_MUL: begin
        au_a = {prod, 1'b0};
        au_b = my[WHOLE_W-1] ? {1'b0, mx} : '0;
      end
      S_DIV: begin
        au_a   = AU_W'(div_trial);
        au_b   = AU_W'(wb);
        au_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign au_sum  = au_a + (au_sub ? ~au_b : au_b) + AU_W'(au_sub);
  assign au_ovf  = |au_sum[AU_W-1:WHOLE_W-1];
  assign div_neg = au_sum[AU_W-1];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign key.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_value   <= '0;
      entry_present <= 1'b0;
      held_value    <= '0;
      held_present  <= 1'b0;
      pend          <= OP_NONE;
      out_valid     <= 1'b0;
    end else begin
      // output register drains independently of the sequencer; the emit state
      // decides the flag itself
      if (result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (key_fire) begin
            if (is_digit) begin
              entry_value   <= digit_next;
              entry_present <= 1'b1;
            end else if (key_op != OP_NONE) begin
              if (!entry_present) begin
                entry_value <= '0;
                st_status   <= ST_MISSING;
                st_whole    <= '0;
                st_frac     <= '0;
                state       <= S_EMIT;
              end else begin
                held_value    <= entry_value;
                held_present  <= 1'b1;
                pend          <= key_op;
                entry_value   <= '0;
                entry_present <= 1'b0;
              end
            end else if (is_enter) begin
              entry_value   <= '0;
              entry_present <= 1'b0;
              st_frac       <= '0;
              if (enter_missing) begin
                st_status <= ST_MISSING;
                st_whole  <= '0;
                state     <= S_EMIT;
              end else begin
                held_value   <= '0;
                held_present <= 1'b0;
                pend         <= OP_NONE;
                wa           <= held_value;
                wb           <= entry_value;
                wop          <= pend;
                case (pend) inside
                  OP_ADD, OP_SUB: begin
                    st_status <= ST_OK;
                    state     <= S_ADDSUB;
                  end
                  OP_MUL: begin
                    st_status <= ST_OK;
                    mx        <= WHOLE_W'(held_value);
                    my        <= {entry_value, {PAD{1'b0}}};
                    prod      <= '0;
                    cnt       <= CNT_W'(OPERAND_BITS);
                    mul_pow   <= 1'b0;
                    state     <= S_MUL;
                  end
                  OP_DIV: begin
                    st_whole <= '0;
                    if (entry_value == '0) begin
                      st_status <= (held_value != '0) ? ST_DIV_ZERO : ST_ZERO_ZERO;
                      state     <= S_EMIT;
                    end else begin
                      st_status <= ST_OK;
                      rem       <= '0;
                      quo       <= {held_value, {FRACTION_BITS{1'b0}}};
                      cnt       <= CNT_W'(QW);
                      state     <= S_DIV;
                    end
                  end
                  default: begin
                    // power: trivial exponent or base finishes at once
                    st_status <= ST_OK;
                    if (entry_value == '0) begin
                      st_whole <= WHOLE_W'(1);
                      state    <= S_EMIT;
                    end else if (held_value <= OB'(1)) begin
                      st_whole <= WHOLE_W'(held_value);
                      state    <= S_EMIT;
                    end else begin
                      acc   <= WHOLE_W'(1);
                      ebit  <= EB_W'(OPERAND_BITS - 1);
                      state <= S_PSQ;
                    end
                  end
                endcase
              end
            end
          end
        end

        S_ADDSUB: begin
          st_whole <= au_sum[WHOLE_W-1:0];
          state    <= S_EMIT;
        end

        S_MUL: begin
          if (mul_pow && au_ovf) begin
            st_status <= ST_OVERFLOW;
            st_whole  <= WHOLE_MAX;
            state     <= S_EMIT;
          end else begin
            prod <= au_sum[WHOLE_W-1:0];
            my   <= {my[WHOLE_W-2:0], 1'b0};
            cnt  <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              if (mul_pow) begin
                acc   <= au_sum[WHOLE_W-1:0];
                state <= ret_state;
              end else begin
                st_whole <= au_sum[WHOLE_W-1:0];
                state    <= S_EMIT;
              end
            end
          end
        end

        S_DIV: begin
          rem <= div_neg ? div_trial[OB-1:0] : au_sum[OB-1:0];
          quo <= {quo[QW-2:0], ~div_neg};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            st_whole <= WHOLE_W'(quo[QW-2:FRACTION_BITS-1]);
            st_frac  <= FRAC_OUT_W'({quo[FRACTION_BITS-2:0], ~div_neg});
            state    <= S_EMIT;
          end
        end

        S_PSQ: begin
          // squaring one leaves one
          if (acc == WHOLE_W'(1)) begin
            state <= S_PBIT;
          end else begin
            mx        <= acc;
            my        <= acc;
            prod      <= '0;
            cnt       <= CNT_W'(WHOLE_W);
            mul_pow   <= 1'b1;
            ret_state <= S_PBIT;
            state     <= S_MUL;
          end
        end

        S_PBIT: begin
          if (wb[ebit]) begin
            mx        <= acc;
            my        <= {wa, {PAD{1'b0}}};
            prod      <= '0;
            cnt       <= CNT_W'(OPERAND_BITS);
            mul_pow   <= 1'b1;
            ret_state <= S_PNEXT;
            state     <= S_MUL;
          end else begin
            state <= S_PNEXT;
          end
        end

        S_PNEXT: begin
          if (ebit == '0) begin
            st_whole <= acc;
            state    <= S_EMIT;
          end else begin
            ebit  <= ebit - EB_W'(1);
            state <= S_PSQ;
          end
        end

        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= st_status;
            out_whole  <= st_whole;
            out_frac   <= st_frac;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.status          = out_status;
  assign result.result_whole    = $signed(out_whole);
  assign result.result_fraction = out_frac;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_held_matches_pend: assert property (@(posedge clk) disable iff (rst)
    held_present == (pend != OP_NONE))
    else $error("held operand flag disagrees with pending operation");

  a_entry_clear: assert property (@(posedge clk) disable iff (rst)
    !entry_present |-> (entry_value == '0))
    else $error("absent entry holds a nonzero value");

  a_mul_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && !mul_pow) |-> !au_ovf)
    else $error("plain product overflowed 63 bits");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < wb))
    else $error("partial remainder not below divisor");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result loaded outside the emit state");

endmodule

/* test/kc_checker.sv */
`timescale 1ns / 100ps
// kc_checker: watches the key and result channels of the keystroke calculator,
// predicts every result from the accepted keys and compares field by field
// depends on kc_pkg, kc_key_if, kc_res_if
module kc_checker #(
  parameter int OPERAND_BITS  = 31,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  kc_key_if    key,
  kc_res_if    result,
  output int   fail_count,
  output int   outstanding
);
  import kc_pkg::*;

  localparam logic [63:0] OPERAND_MAX = (64'd1 << OPERAND_BITS) - 64'd1;

  typedef struct packed {
    status_t status;
    whole_t  whole;
    frac_t   fraction;
  } calc_result_t;

  calc_result_t awaited_results[$];
  calc_result_t oldest;

  // calculator state
  logic [63:0] entry_val;
  bit          entry_set;
  logic [63:0] held_val;
  bit          held_set;
  op_t         pend_op;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic op_t key_op(input key_t k);
    case (k)
      KEY_ADD: return OP_ADD;
      KEY_SUB: return OP_SUB;
      KEY_MUL: return OP_MUL;
      KEY_DIV: return OP_DIV;
      KEY_POW: return OP_POW;
      default: return OP_NONE;
    endcase
  endfunction

  // square and multiply over all 32 exponent bits, saturating at the 63-bit maximum
  function automatic logic [63:0] power_sat(input logic [63:0] base,
                                            input logic [63:0] expo, output bit ovf);
    logic [63:0] acc;
    int          i;
    ovf = 1'b0;
    acc = 64'd1;
    if (expo == 64'd0) return 64'd1;
    if (base <= 64'd1) return base;
    for (i = 31; i >= 0; i--) begin
      if (acc != 64'd0 && acc > WHOLE_MAX / acc) begin
        ovf = 1'b1;
        return WHOLE_MAX;
      end
      acc = acc * acc;
      if (expo[i]) begin
        if (acc > WHOLE_MAX / base) begin
          ovf = 1'b1;
          return WHOLE_MAX;
        end
        acc = acc * base;
      end
    end
    return acc;
  endfunction

  task automatic apply_keystroke(input key_t k);
    op_t          op;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  v;
    bit           ovf;
    calc_result_t res;
    res = '0;
    op  = key_op(k);
    if (k >= KEY_ZERO && k <= KEY_NINE) begin
      if (!entry_set) begin
        entry_val = 64'(k) - 64'(KEY_ZERO);
        entry_set = 1'b1;
      end else begin
        v = entry_val * 64'd10 + (64'(k) - 64'(KEY_ZERO));
        entry_val = (v > OPERAND_MAX) ? OPERAND_MAX : v;
      end
    end else if (op != OP_NONE) begin
      if (!entry_set) begin
        entry_val  = 64'd0;
        res.status = ST_MISSING;
        awaited_results.push_back(res);
      end else begin
        held_val  = entry_val;
        held_set  = 1'b1;
        pend_op   = op;
        entry_val = 64'd0;
        entry_set = 1'b0;
      end
    end else if (k == KEY_ENTER) begin
      if (!entry_set || !held_set || pend_op == OP_NONE || pend_op > OP_POW) begin
        entry_val  = 64'd0;
        entry_set  = 1'b0;
        res.status = ST_MISSING;
      end else begin
        a = held_val;
        b = entry_val;
        case (pend_op)
          OP_ADD: res.whole = a + b;
          OP_SUB: res.whole = a - b;
          OP_MUL: res.whole = a * b;
          OP_DIV: begin
            if (b == 64'd0) begin
              res.status = (a != 64'd0) ? ST_DIV_ZERO : ST_ZERO_ZERO;
            end else begin
              res.whole    = a / b;
              v            = ((a % b) << FRACTION_BITS) / b;
              res.fraction = v[FRAC_OUT_W-1:0];
            end
          end
          default: begin
            res.whole = power_sat(a, b, ovf);
            if (ovf) res.status = ST_OVERFLOW;
          end
        endcase
        entry_val = 64'd0;
        entry_set = 1'b0;
        held_val  = 64'd0;
        held_set  = 1'b0;
        pend_op   = OP_NONE;
      end
      awaited_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      entry_val = 64'd0;
      entry_set = 1'b0;
      held_val  = 64'd0;
      held_set  = 1'b0;
      pend_op   = OP_NONE;
      awaited_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d whole %0d",
                                    result.status, result.result_whole));
        end else begin
          oldest = awaited_results.pop_front();
          if (result.status !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, oldest.status));
          if (result.result_whole !== oldest.whole)
            report_mismatch($sformatf("result_whole %0d, expected %0d",
                                      result.result_whole, $signed(oldest.whole)));
          if (result.result_fraction !== oldest.fraction)
            report_mismatch($sformatf("result_fraction %0h, expected %0h",
                                      result.result_fraction, oldest.fraction));
        end
      end
      if (key.valid && key.ready) apply_keystroke(key.key_code);
    end
    outstanding = awaited_results.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives keystrokes into keystroke_calculator_core and gives the verdict
// depends on kc_pkg, kc_key_if, kc_res_if, keystroke_calculator_core, kc_checker
module testbench;
  import kc_pkg::*;

  localparam int OPERAND_BITS  = 31;
  localparam int FRACTION_BITS = 16;
  localparam int CLK_PERIOD    = 12;
  // digit, operator and enter keys sent in the random part, spread over three phases
  localparam int RANDOM_KEYS   = 1170;
  // settle wait after the final drain, meant to outlast the longest power evaluation
  localparam int SETTLE_CYCLES = 3200;
  localparam int TIMEOUT_NS    = 200_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int key_idle_pct;
  int res_idle_pct;
  int keys_sent;
  int fail_count;
  int outstanding;

  kc_key_if key_ch ();
  kc_res_if res_ch ();

  keystroke_calculator_core #(
    .OPERAND_BITS  (OPERAND_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .key    (key_ch),
    .result (res_ch)
  );

  kc_checker #(
    .OPERAND_BITS  (OPERAND_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .key         (key_ch),
    .result      (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // all inputs known from time zero
  initial begin
    key_ch.valid    = 1'b0;
    key_ch.key_code = '0;
    res_ch.ready    = 1'b0;
    key_idle_pct    = 23;
    res_idle_pct    = 74;
    keys_sent       = 0;
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= res_idle_pct);
  end

  // digits, operators and enter; everything else the calculator ignores
  function automatic bit is_active_key(input key_t k);
    return (k >= KEY_ZERO && k <= KEY_NINE) || k == KEY_ADD || k == KEY_SUB ||
           k == KEY_MUL || k == KEY_DIV || k == KEY_POW || k == KEY_ENTER;
  endfunction

  function automatic key_t op_key_code(input op_t op);
    case (op)
      OP_ADD:  return KEY_ADD;
      OP_SUB:  return KEY_SUB;
      OP_MUL:  return KEY_MUL;
      OP_DIV:  return KEY_DIV;
      default: return KEY_POW;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_key(input key_t k);
    while ($urandom_range(99) < key_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_code <= k;
    do @(posedge clk); while (!key_ch.ready);
    @(negedge clk);
    if (is_active_key(k)) keys_sent++;
  endtask

  // '=' stands for the enter key
  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (s[i] == "=") send_key(KEY_ENTER);
      else send_key(key_t'(s[i]));
    end
  endtask

  // hold the key channel off until every predicted result has come back
  task automatic wait_results_drained();
    key_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // decimal operand text: zero, small, medium, full 32-bit, the saturation
  // boundary, or a digit run long enough to saturate
  function automatic string random_operand();
    int unsigned pick;
    int          n;
    int          i;
    string       s;
    pick = $urandom_range(99);
    if (pick < 10) s = "0";
    else if (pick < 45) s = $sformatf("%0d", $urandom_range(1, 999));
    else if (pick < 70) s = $sformatf("%0d", $urandom_range(1, 99999));
    else if (pick < 88) s = $sformatf("%0d", $urandom());
    else if (pick < 95) s = $sformatf("%0d", 64'd2147483646 + $urandom_range(2));
    else begin
      s = $sformatf("%0d", $urandom_range(1, 9));
      n = $urandom_range(10, 11);
      for (i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    // leading zero now and then
    if ($urandom_range(9) == 0) s = {"0", s};
    return s;
  endfunction

  // one operation with random content, sometimes broken on purpose
  task automatic send_calculation();
    op_t         op;
    string       lhs;
    string       rhs;
    int unsigned flavor;
    int unsigned r;
    op = op_t'($urandom_range(OP_ADD, OP_POW));
    if (op == OP_POW) begin
      // keep most powers inside range so both ok and overflow show up
      r = $urandom_range(99);
      if (r < 30) lhs = $sformatf("%0d", $urandom_range(3));
      else if (r < 80) lhs = $sformatf("%0d", $urandom_range(20));
      else lhs = random_operand();
      if ($urandom_range(99) < 85) rhs = $sformatf("%0d", $urandom_range(70));
      else rhs = random_operand();
    end else begin
      lhs = random_operand();
      rhs = random_operand();
    end
    flavor = $urandom_range(99);
    send_text(lhs);
    // an earlier operator that gets replaced without being computed
    if (flavor < 8) begin
      send_key(op_key_code(op_t'($urandom_range(OP_ADD, OP_POW))));
      send_text(random_operand());
    end
    send_key(op_key_code(op));
    // repeated operator with the entry already cleared
    if (flavor >= 8 && flavor < 12) send_key(op_key_code(op));
    // stray ignored key inside the sequence
    if (flavor >= 12 && flavor < 16) send_key(key_t'($urandom_range(128, 255)));
    // enter with the second operand missing
    if (flavor < 16 || flavor >= 20) send_text(rhs);
    send_key(KEY_ENTER);
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1)) send_key(key_t'($urandom_range(0, 255)));
      else begin
        case ($urandom_range(2))
          0:       send_key(KEY_ENTER);
          1:       send_key(op_key_code(op_t'($urandom_range(OP_ADD, OP_POW))));
          default: send_key(key_t'($urandom_range(KEY_ZERO, KEY_NINE)));
        endcase
      end
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: enter alone, operator with no entry, zero by zero,
    // divide by zero, zero to the zero, negative difference, replaced
    // operator with a zero held operand, overflowing power with an ignored
    // key in the exponent, and the two extreme key codes
    send_text("=+0/0=5/0=0^0=3-8=6+0*9=9^9a9=");
    send_key(8'd0);
    send_key(8'hFF);

    // random part in three phases of idling, draining at each boundary
    for (phase = 0; phase < 3; phase++) begin
      wait_results_drained();
      case (phase)
        0: begin
          key_idle_pct = 23;
          res_idle_pct = 74;
        end
        1: begin
          key_idle_pct = 74;
          res_idle_pct = 23;
        end
        default: begin
          key_idle_pct = 0;
          res_idle_pct = 0;
        end
      endcase
      target = keys_sent + RANDOM_KEYS / 3;
      while (keys_sent < target) begin
        if ($urandom_range(99) < 80) send_calculation();
        else send_noise();
        // occasional full drain in the middle of a phase
        if ($urandom_range(99) < 3) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/kc_pkg.sv
hdl/kc_key_if.sv
hdl/kc_res_if.sv
hdl/keystroke_calculator_core.sv
test/kc_checker.sv
test/testbench.sv
